@@ hdl/lrukv_pkg.sv @@
package lrukv_pkg;

  localparam int KEY_W     = 32;
  localparam int VAL_W     = 32;
  localparam int CAP_W     = 5;
  localparam int ACT_W     = 2;
  localparam int EVCNT_W   = 5;
  localparam int RESET_CAP = 16;

  // item opcodes; the spare code is a no-op handled by default arms
  typedef enum logic [ACT_W-1:0] {
    ACT_GET    = 2'd0,
    ACT_PUT    = 2'd1,
    ACT_RESIZE = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_UPDATE,
    ST_FINISH
  } ctrl_state_t;

  // controller to datapath strobes
  typedef struct packed {
    logic latch;   // capture the input word
    logic search;  // register key match and slot search
    logic update;  // apply the operation to the store
    logic load;    // move the result into the output register
  } dp_cmd_t;

endpackage

@@ hdl/lru_key_value_cache_unit.sv @@
// LRU key/value cache: fully associative, ENTRIES slots, 32-bit keys and values.
// Input channel (in_valid/in_ready) takes one word: action (get, put, resize),
// lookup_key, write_value, new_capacity. Output channel (out_valid/out_ready)
// returns one result word per input word, in order: hit, read_value,
// evicted, evicted_key, evicted_count.
// Config channel (cfg_valid/cfg_ready, always ready) loads start_capacity into
// the live capacity, saturated to ENTRIES; write it only while the unit is idle.
// From input accept to out_valid the word passes key match and slot search,
// store update with value read, and output load. The controller handles one word
// at a time and takes the next one in the cycle after the load, so it cannot take
// a new word before the last one is through; the sequence is set by the single controller
// walking search, update and load in turn.
// A resize evicts all surplus entries in the update state, so it takes no extra states.
// The output register parts the channels: the next input word is taken while
// a result waits; if the receiver stalls, the following result holds in the
// finish state until the output register drains.
// Reset (rst, synchronous): store empty, live capacity sixteen (capped at
// ENTRIES), no result pending. Stored keys and values are not cleared.
module lru_key_value_cache_unit import lrukv_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  // config
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CAP_W-1:0]        start_capacity,
  // input words
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [ACT_W-1:0]        action,
  input  logic signed [KEY_W-1:0] lookup_key,
  input  logic signed [VAL_W-1:0] write_value,
  input  logic [CAP_W-1:0]        new_capacity,
  // result words
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    hit,
  output logic signed [VAL_W-1:0] read_value,
  output logic                    evicted,
  output logic signed [KEY_W-1:0] evicted_key,
  output logic [EVCNT_W-1:0]      evicted_count
);

  dp_cmd_t cmd;
  logic    cfg_we;

  // config writes are always taken, no back-pressure needed
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;

  lrukv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  lrukv_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .cfg_we        (cfg_we),
    .cfg_cap       (start_capacity),
    .action        (action),
    .lookup_key    (lookup_key),
    .write_value   (write_value),
    .new_capacity  (new_capacity),
    .hit           (hit),
    .read_value    (read_value),
    .evicted       (evicted),
    .evicted_key   (evicted_key),
    .evicted_count (evicted_count)
  );

`ifndef SYNTHESIS
  // one word in flight: an accept is never followed straight by another
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a word is in flight");

  // an eviction by put removes exactly one entry and never coincides with a hit
  a_evict_single: assert property (@(posedge clk) disable iff (rst)
    (out_valid && evicted) |-> (evicted_count == EVCNT_W'(1) && !hit))
    else $error("put eviction result inconsistent");

  // a real read value only comes with a hit
  a_value_needs_hit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !hit) |-> (read_value == -32'sd1))
    else $error("read value without hit");
`endif

endmodule

@@ hdl/lrukv_ctrl.sv @@
module lrukv_ctrl import lrukv_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd
);

  ctrl_state_t state, state_next;
  logic        out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid && !out_ready;
    in_ready       = 1'b0;
    cmd            = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        cmd.search = 1'b1;
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        // wait here only while the previous result is still unread
        if (!out_valid || out_ready) begin
          cmd.load       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ hdl/lrukv_dp.sv @@
module lrukv_dp import lrukv_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  dp_cmd_t                   cmd,
  input  logic                      cfg_we,
  input  logic [CAP_W-1:0]          cfg_cap,
  input  logic [ACT_W-1:0]          action,
  input  logic signed [KEY_W-1:0]   lookup_key,
  input  logic signed [VAL_W-1:0]   write_value,
  input  logic [CAP_W-1:0]          new_capacity,
  output logic                      hit,
  output logic signed [VAL_W-1:0]   read_value,
  output logic                      evicted,
  output logic signed [KEY_W-1:0]   evicted_key,
  output logic [EVCNT_W-1:0]        evicted_count
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int XW = (CW > CAP_W) ? CW : CAP_W;

  function automatic logic [CW-1:0] clamp_cap(input logic [CAP_W-1:0] c);
    logic [XW-1:0] e;
    e = XW'(c);
    if (e > XW'(ENTRIES)) return CW'(ENTRIES);
    return CW'(e);
  endfunction

  // latched item
  action_t          act_q;
  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] val_q;
  logic [CAP_W-1:0] ncap_q;

  // store
  logic [KEY_W-1:0] keys   [ENTRIES];
  logic [VAL_W-1:0] values [ENTRIES];
  logic [ENTRIES-1:0] valid;
  logic [IW-1:0]    rank   [ENTRIES];
  logic [CW-1:0]    count;
  logic [CW-1:0]    live_cap;

  // search results
  logic          hit_q, free_any_q;
  logic [IW-1:0] hit_slot_q, hit_rank_q, vict_slot_q, free_slot_q;

  // result staging
  logic [VAL_W-1:0]   rdata_q;
  logic               res_hit, res_get_hit, res_ev;
  logic [KEY_W-1:0]   res_evkey;
  logic [EVCNT_W-1:0] res_evc;

  // search logic
  logic          hit_any, free_any;
  logic [IW-1:0] hit_idx, vict_idx, free_idx;

  always_comb begin
    hit_any  = 1'b0;
    free_any = 1'b0;
    hit_idx  = '0;
    vict_idx = '0;
    free_idx = '0;
    // walk downwards so that the lowest matching slot wins
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (valid[i] && keys[i] == key_q) begin
        hit_any = 1'b1;
        hit_idx = IW'(i);
      end
      if (valid[i] && CW'(rank[i]) == count - CW'(1)) begin
        vict_idx = IW'(i);
      end
      if (!valid[i]) begin
        free_any = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      act_q  <= action_t'(action);
      key_q  <= lookup_key;
      val_q  <= write_value;
      ncap_q <= new_capacity;
    end
    if (cmd.search) begin
      hit_q       <= hit_any;
      hit_slot_q  <= hit_idx;
      hit_rank_q  <= rank[hit_idx];
      vict_slot_q <= vict_idx;
      free_any_q  <= free_any;
      free_slot_q <= free_idx;
    end
  end

  // update decode
  logic          do_evict;
  logic [IW-1:0] ins_slot;
  logic [CW-1:0] rcap;
  logic          is_put, is_get, is_resize;

  always_comb begin
    is_get    = (act_q == ACT_GET);
    is_put    = (act_q == ACT_PUT);
    is_resize = (act_q == ACT_RESIZE);
    do_evict  = is_put && !hit_q && (count != '0) &&
                ((count >= live_cap) || (count == CW'(ENTRIES)));
    ins_slot  = (do_evict && (!free_any_q || vict_slot_q < free_slot_q)) ?
                vict_slot_q : free_slot_q;
    rcap      = clamp_cap(ncap_q);
  end

  // control state of the store
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      count    <= '0;
      live_cap <= clamp_cap(CAP_W'(RESET_CAP));
      for (int j = 0; j < ENTRIES; j++) rank[j] <= '0;
    end else if (cfg_we) begin
      live_cap <= clamp_cap(cfg_cap);
    end else if (cmd.update) begin
      case (act_q)
        ACT_GET, ACT_PUT: begin
          if (hit_q) begin
            for (int j = 0; j < ENTRIES; j++) begin
              if (valid[j] && rank[j] < hit_rank_q) rank[j] <= rank[j] + IW'(1);
            end
            rank[hit_slot_q] <= '0;
          end else if (is_put) begin
            for (int j = 0; j < ENTRIES; j++) begin
              if (valid[j] && !(do_evict && IW'(j) == vict_slot_q)) begin
                rank[j] <= rank[j] + IW'(1);
              end
            end
            if (do_evict) valid[vict_slot_q] <= 1'b0;
            valid[ins_slot] <= 1'b1;
            rank[ins_slot]  <= '0;
            if (!do_evict) count <= count + CW'(1);
          end
        end
        ACT_RESIZE: begin
          live_cap <= rcap;
          // ranks are dense, so every rank at or past the new capacity goes
          for (int j = 0; j < ENTRIES; j++) begin
            if (valid[j] && CW'(rank[j]) >= rcap) valid[j] <= 1'b0;
          end
          if (count > rcap) count <= rcap;
        end
        default: begin
        end
      endcase
    end
  end

  // key row and value memory
  always_ff @(posedge clk) begin
    if (cmd.update && is_put && !hit_q) keys[ins_slot] <= key_q;
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      if (is_put) values[hit_q ? hit_slot_q : ins_slot] <= val_q;
      rdata_q <= values[hit_slot_q];
    end
  end

  // result staging
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      res_hit     <= hit_q && (is_get || is_put);
      res_get_hit <= hit_q && is_get;
      res_ev      <= do_evict;
      res_evkey   <= do_evict ? keys[vict_slot_q] : '0;
      if (is_put) res_evc <= do_evict ? EVCNT_W'(1) : '0;
      else if (is_resize && count > rcap) res_evc <= EVCNT_W'(count - rcap);
      else res_evc <= '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hit           <= res_hit;
      read_value    <= res_get_hit ? rdata_q : '1;
      evicted       <= res_ev;
      evicted_key   <= res_evkey;
      evicted_count <= res_evc;
    end
  end

endmodule
